/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define CHK_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/pacd_pkg.sv */
`timescale 1ns / 1ps

package pacd_pkg;

  localparam int unsigned MAX_BLOCK = 4096;
  localparam int unsigned CNT_W     = $clog2(MAX_BLOCK);
  localparam int unsigned SPB_W     = 13;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PHASE_W-1:0] ACC_STEP_RST   = 32'h8000_0000;
  localparam logic [SPB_W-1:0]   SPB_RST        = 13'd4000;
  localparam logic [SPB_W-1:0]   MAX_BLOCK_SPB  = SPB_W'(MAX_BLOCK);
  localparam logic [CNT_W-1:0]   MAX_LEN_M1     = CNT_W'(MAX_BLOCK - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACC_STEP          = 2'd0,
    REG_SAMPLES_PER_BLOCK = 2'd1,
    REG_DUAL_CHANNEL      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_real;
    logic signed [SAMPLE_W-1:0] in_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_real;
    logic signed [SAMPLE_W-1:0] out_imag;
    logic                       channel;
    logic [CNT_W-1:0]           out_index;
    logic                       block_end;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] acc_step;
    logic [SPB_W-1:0]   samples_per_block;
    logic               dual_channel;
  } cfg_t;

  typedef struct packed {
    logic      keep;
    out_item_t item;
  } core_res_t;

endpackage

/* rtl/pacd_cfg.sv */
`timescale 1ns / 1ps

module pacd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [pacd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [pacd_pkg::PHASE_W-1:0]     wr_data,
  output pacd_pkg::cfg_t                   cfg
);

  pacd_pkg::cfg_t cfg_r;
  pacd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      if (wr_index == pacd_pkg::REG_ACC_STEP) begin
        cfg_nxt.acc_step = wr_data;
      end else if (wr_index == pacd_pkg::REG_SAMPLES_PER_BLOCK) begin
        cfg_nxt.samples_per_block = wr_data[pacd_pkg::SPB_W-1:0];
      end else if (wr_index == pacd_pkg::REG_DUAL_CHANNEL) begin
        cfg_nxt.dual_channel = wr_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.acc_step          <= pacd_pkg::ACC_STEP_RST;
      cfg_r.samples_per_block <= pacd_pkg::SPB_RST;
      cfg_r.dual_channel      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/pacd_core.sv */
`timescale 1ns / 1ps

module pacd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pacd_pkg::cfg_t       cfg,
  input  logic                 fire,
  input  pacd_pkg::in_item_t   item,
  output pacd_pkg::core_res_t  res
);

  logic [pacd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [pacd_pkg::PHASE_W-1:0] prev_phase_r, prev_phase_nxt;
  logic [pacd_pkg::CNT_W-1:0]   block_count_r, block_count_nxt;
  logic [pacd_pkg::CNT_W-1:0]   out_count_r, out_count_nxt;
  logic                         expect_b_r, expect_b_nxt;
  logic                         keep_pair_r, keep_pair_nxt;

  logic [pacd_pkg::SPB_W-1:0]   spb_m1;
  logic [pacd_pkg::CNT_W-1:0]   len_m1;
  logic                         last;
  logic                         wrapped;
  logic                         keep;
  logic                         chan_b;
  logic                         adv;

  // Clamp the block length to 1..MAX_BLOCK, kept as length minus one.
  always_comb begin
    spb_m1 = cfg.samples_per_block - pacd_pkg::SPB_W'(1);
    if (cfg.samples_per_block == '0) begin
      len_m1 = '0;
    end else if (cfg.samples_per_block > pacd_pkg::MAX_BLOCK_SPB) begin
      len_m1 = pacd_pkg::MAX_LEN_M1;
    end else begin
      len_m1 = spb_m1[pacd_pkg::CNT_W-1:0];
    end
  end

  assign last    = (block_count_r >= len_m1);
  assign wrapped = (phase_r <= prev_phase_r);

  always_comb begin
    keep          = wrapped;
    chan_b        = 1'b0;
    adv           = 1'b1;
    expect_b_nxt  = expect_b_r;
    keep_pair_nxt = keep_pair_r;
    if (!cfg.dual_channel) begin
      expect_b_nxt = 1'b0;
    end else if (!expect_b_r) begin
      // A half: decide for the pair, hold the phase
      keep_pair_nxt = wrapped;
      expect_b_nxt  = 1'b1;
      adv           = 1'b0;
    end else begin
      keep          = keep_pair_r;
      chan_b        = 1'b1;
      expect_b_nxt  = 1'b0;
      keep_pair_nxt = 1'b0;
    end

    phase_nxt       = phase_r;
    prev_phase_nxt  = prev_phase_r;
    block_count_nxt = block_count_r;
    out_count_nxt   = out_count_r;
    if (adv) begin
      if (last) begin
        phase_nxt       = '0;
        prev_phase_nxt  = '0;
        block_count_nxt = '0;
        out_count_nxt   = '0;
      end else begin
        phase_nxt       = phase_r + cfg.acc_step;
        prev_phase_nxt  = phase_r;
        block_count_nxt = block_count_r + pacd_pkg::CNT_W'(1);
        out_count_nxt   = out_count_r + pacd_pkg::CNT_W'(keep);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      prev_phase_r  <= '0;
      block_count_r <= '0;
      out_count_r   <= '0;
      expect_b_r    <= 1'b0;
      keep_pair_r   <= 1'b0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      prev_phase_r  <= prev_phase_nxt;
      block_count_r <= block_count_nxt;
      out_count_r   <= out_count_nxt;
      expect_b_r    <= expect_b_nxt;
      keep_pair_r   <= keep_pair_nxt;
    end
  end

  always_comb begin
    res.keep                = keep;
    res.item.out_real       = item.in_real;
    res.item.out_imag       = item.in_imag;
    res.item.channel        = chan_b;
    res.item.out_index      = out_count_r;
    res.item.block_end      = last;
  end

endmodule

/* rtl/phase_accumulator_decimator_top.sv */
`timescale 1ns / 1ps

// Phase-accumulator decimator for complex 16-bit samples, single channel or
// interleaved A/B pairs. One input item is taken every clock while the result
// side keeps up; each item yields zero or one result item, held first in the
// input register, then in the result register. The rate rests on the 32-bit
// phase add and wrap compare in pacd_core, both combinational. A sample is kept
// when the accumulator wraps; the first sample of every block is kept. In dual
// mode the A half makes the keep decision for the pair and the B half advances
// the phase, so both halves share one output index. Configuration (phase
// increment, samples_per_block, dual_channel) goes through cfg_*; the user must
// write it only while the block is idle (not enforced); cfg_ready is always high.
module phase_accumulator_decimator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input samples
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pacd_pkg::in_item_t              in_item,
  // kept samples
  output logic                            out_valid,
  input  logic                            out_stall,
  output pacd_pkg::out_item_t             out_item,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pacd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pacd_pkg::PHASE_W-1:0]    cfg_data
);

  pacd_pkg::cfg_t      cfg;
  pacd_pkg::core_res_t res;

  // input register stage
  logic                s0_valid_r, s0_valid_nxt;
  pacd_pkg::in_item_t  s0_item_r;

  // result register stage
  logic                out_valid_r, out_valid_nxt;
  pacd_pkg::out_item_t out_item_r;

  logic out_free;
  logic s0_fire;
  logic in_accept;

  assign cfg_ready = 1'b1;

  pacd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Result register is free when empty or being drained this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign s0_fire   = s0_valid_r && out_free;
  assign in_stall  = s0_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  pacd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (s0_fire),
    .item  (s0_item_r),
    .res   (res)
  );

  always_comb begin
    s0_valid_nxt  = in_stall ? s0_valid_r : in_valid;
    out_valid_nxt = out_free ? (s0_fire && res.keep) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_item_r <= in_item;
    end
    if (s0_fire && res.keep) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/pacd_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pacd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pacd_pkg::out_item_t out_item
);

  `CHK_ALWAYS(a_rst_out_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `CHK_ALWAYS(a_rst_in_open, !rst_n |=> !in_stall, "input stalled right after reset")
  `CHK_RUN(a_stall_only_back, in_stall |-> (out_valid && out_stall), "spurious input stall")
  `CHK_RUN(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `CHK_RUN(a_out_stable, out_valid && out_stall |=> $stable(out_item), "stalled result changed")

endmodule

bind phase_accumulator_decimator_top pacd_checker u_pacd_checker (.*);
